>>> hdl/twr_pkg.sv
// ----------------------------------------------------------------------------
// twr_pkg
// Shared types and constants for the TFTP write receiver.
// ----------------------------------------------------------------------------
package twr_pkg;

  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic [15:0] OpWrq         = 16'd2;
  localparam logic [15:0] OpData        = 16'd3;
  localparam logic [10:0] FullPacketLen = 11'd516;
  localparam logic [10:0] HdrBytes      = 11'd4;
  localparam logic [10:0] MaxPayload    = 11'd1020;
  localparam logic [7:0]  TimeoutReset  = 8'd10;
  localparam logic [7:0]  QuietMax      = 8'd255;

  localparam logic       FuncPacket = 1'b0;
  localparam logic       FuncTick   = 1'b1;
  localparam logic [0:0] RegTimeout = 1'b0;

  typedef enum logic [1:0] {
    END_NONE    = 2'd0,
    END_DONE    = 2'd1,
    END_TIMEOUT = 2'd2
  } end_code_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_RECV = 2'b10
  } phase_e;

  typedef struct packed {
    logic        func;
    logic [15:0] opcode;
    logic [15:0] block_number;
    logic [10:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic        send_ack;
    logic [15:0] ack_block;
    logic        write_payload;
    logic [9:0]  payload_length;
    logic        transfer_start;
    logic [1:0]  transfer_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] timeout_seconds;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } buf_status_t;

endpackage

>>> hdl/twr_regs.sv
// ----------------------------------------------------------------------------
// twr_regs
// Configuration register bank behind the APB-style port.
// ----------------------------------------------------------------------------
module twr_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [twr_pkg::AddrWidth-1:0]       paddr,
  input  logic [twr_pkg::DataWidth-1:0]       pwdata,
  output logic [twr_pkg::DataWidth-1:0]       prdata,
  output logic                                pready,
  output twr_pkg::cfg_t                       cfg_o
);

  logic [7:0] timeout_q, timeout_d;
  logic       sel_timeout;

  assign pready      = 1'b1;
  assign sel_timeout = (paddr[2] == twr_pkg::RegTimeout);

  always_comb begin
    timeout_d = timeout_q;
    if (psel && penable && pwrite && sel_timeout) begin
      timeout_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= twr_pkg::TimeoutReset;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  assign prdata = sel_timeout ? {{(twr_pkg::DataWidth-8){1'b0}}, timeout_q}
                              : '0;
  assign cfg_o.timeout_seconds = timeout_q;

endmodule

>>> hdl/twr_fsm.sv
// ----------------------------------------------------------------------------
// twr_fsm
// Transfer state and the per-item decision logic.
// ----------------------------------------------------------------------------
module twr_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  twr_pkg::in_item_t item_i,
  input  twr_pkg::cfg_t     cfg_i,
  output twr_pkg::out_item_t res_o
);

  twr_pkg::phase_e phase_q, phase_d;
  logic [15:0]     expected_q, expected_d;
  logic [7:0]      quiet_q, quiet_d;
  logic [15:0]     prev_block;
  logic [7:0]      quiet_inc;
  logic [10:0]     len_minus;
  logic            is_data;

  assign prev_block = expected_q - 16'd1;
  assign quiet_inc  = (quiet_q == twr_pkg::QuietMax) ? quiet_q : quiet_q + 8'd1;
  assign len_minus  = item_i.packet_length - twr_pkg::HdrBytes;
  assign is_data    = (item_i.opcode == twr_pkg::OpData);

  always_comb begin
    phase_d    = phase_q;
    expected_d = expected_q;
    quiet_d    = quiet_q;
    res_o      = '0;
    case (phase_q)
      twr_pkg::PH_RECV: begin
        if (item_i.func == twr_pkg::FuncPacket) begin
          if (is_data && item_i.block_number == expected_q) begin
            res_o.write_payload = 1'b1;
            if (item_i.packet_length < twr_pkg::HdrBytes) begin
              res_o.payload_length = '0;
            end else if (len_minus > twr_pkg::MaxPayload) begin
              res_o.payload_length = twr_pkg::MaxPayload[9:0];
            end else begin
              res_o.payload_length = len_minus[9:0];
            end
            res_o.send_ack  = 1'b1;
            res_o.ack_block = expected_q;
            expected_d      = expected_q + 16'd1;
            quiet_d         = '0;
          end else if (is_data && item_i.block_number == prev_block) begin
            res_o.send_ack  = 1'b1;
            res_o.ack_block = prev_block;
          end
          if (item_i.packet_length != twr_pkg::FullPacketLen) begin
            res_o.transfer_end = twr_pkg::END_DONE;
            phase_d            = twr_pkg::PH_IDLE;
          end
        end else begin
          quiet_d = quiet_inc;
          if (quiet_inc >= cfg_i.timeout_seconds) begin
            res_o.transfer_end = twr_pkg::END_TIMEOUT;
            phase_d            = twr_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        phase_d = twr_pkg::PH_IDLE;
        if (item_i.func == twr_pkg::FuncPacket && item_i.opcode == twr_pkg::OpWrq) begin
          res_o.send_ack       = 1'b1;
          res_o.transfer_start = 1'b1;
          expected_d           = 16'd1;
          quiet_d              = '0;
          phase_d              = twr_pkg::PH_RECV;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= twr_pkg::PH_IDLE;
      expected_q <= '0;
      quiet_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      expected_q <= expected_d;
      quiet_q    <= quiet_d;
    end
  end

endmodule

>>> hdl/twr_out_buf.sv
// ----------------------------------------------------------------------------
// twr_out_buf
// Two-entry result buffer that decouples the output stall from the input.
// ----------------------------------------------------------------------------
module twr_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  twr_pkg::out_item_t  data_i,
  input  logic                pop_i,
  output twr_pkg::out_item_t  data_o,
  output twr_pkg::buf_status_t status_o
);

  twr_pkg::out_item_t slot_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = slot_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);

endmodule

>>> hdl/tftp_write_receiver_core.sv
// ----------------------------------------------------------------------------
// tftp_write_receiver_core
// Receiving side of a TFTP write transfer, one result per input item.
// ----------------------------------------------------------------------------
// Each input transfer carries either a parsed packet header or a one-second
// tick, and produces exactly one result transfer with the acknowledgement,
// payload write, start and end indications for that item.
// Input and output use valid and stall; a transfer happens when valid is high
// and stall is low. An accepted item updates the transfer state at the same
// edge and its result is written into a two-entry output buffer, so it can be
// taken from the cycle after acceptance. Throughput is one item per cycle
// while the input stall is low. When the receiver stalls, the buffer holds
// up to two results and the input stall rises once both entries are in use;
// the input stall is driven from the buffer fill level alone.
// The timeout register must be written through the APB-style port while no
// item is in flight (the block does not enforce this); reads return it. Reset
// makes the block idle with an empty buffer and a timeout of ten seconds.
// ----------------------------------------------------------------------------
module tftp_write_receiver_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  twr_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output twr_pkg::out_item_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twr_pkg::AddrWidth-1:0] paddr,
  input  logic [twr_pkg::DataWidth-1:0] pwdata,
  output logic [twr_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  twr_pkg::cfg_t        cfg;
  twr_pkg::out_item_t   result;
  twr_pkg::buf_status_t buf_status;
  logic                 in_xfer;
  logic                 out_xfer;

  assign in_stall_o  = buf_status.full;
  assign out_valid_o = ~buf_status.empty;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_xfer    = out_valid_o & ~out_stall_i;

  twr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  twr_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_xfer),
    .item_i (in_data_i),
    .cfg_i  (cfg),
    .res_o  (result)
  );

  twr_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_xfer),
    .data_i   (result),
    .pop_i    (out_xfer),
    .data_o   (out_data_o),
    .status_o (buf_status)
  );

  a_write_has_ack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_payload |-> out_data_o.send_ack)
    else $error("payload write without acknowledgement");

  a_start_acks_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.transfer_start |->
      out_data_o.send_ack && out_data_o.ack_block == '0 &&
      out_data_o.transfer_end == twr_pkg::END_NONE)
    else $error("transfer start without acknowledgement of block zero");

  a_end_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.transfer_end == twr_pkg::END_NONE ||
      out_data_o.transfer_end == twr_pkg::END_DONE ||
      out_data_o.transfer_end == twr_pkg::END_TIMEOUT)
    else $error("invalid transfer end code");

  a_fill_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && out_valid_o && out_stall_i |=> in_stall_o)
    else $error("buffer full but input not stalled");

endmodule

>>> tb/tb_tftp_write_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tftp_write_receiver_core
// Self-checking testbench for the TFTP write receiver core.
// ----------------------------------------------------------------------------
// A short table of hand-written packet headers and ticks comes first, with
// the obvious results typed in. Random phases follow, mostly well-formed
// write transfers with random content, mixed with stray packets and ticks,
// under several timeout settings written over the register port. A final
// transfer runs back to back with the output rarely stalled.
// Every result is compared, field by field, with its typed-in result where the
// table gives one, else with a behavioural receiver model run on each accepted
// item. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_tftp_write_receiver_core;
  import twr_pkg::*;

  localparam int unsigned DirRows     = 25;
  localparam int unsigned PhaseItems  = 265;
  localparam int unsigned FastBlocks  = 60;
  localparam int unsigned StuckLimit  = 2000;
  localparam logic [15:0] OpRrq       = 16'd1;
  localparam logic [15:0] OpNone      = 16'd0;
  localparam out_item_t   NoAction    = '0;

  typedef struct {
    in_item_t  item;
    bit        has_golden;
    out_item_t golden;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  // Hand-written result travelling alongside the item it belongs to.
  logic      gold_en = 1'b0;
  out_item_t gold_res = '0;

  // Receiver model state.
  phase_e      rx_phase = PH_IDLE;
  logic [15:0] next_block = '0;
  logic [7:0]  quiet_cnt = '0;
  logic [7:0]  timeout_cfg = TimeoutReset;

  out_item_t   expected_results [$];
  dir_row_t    dir_rows [DirRows];
  int          err_cnt = 0;
  int          stuck_cycles = 0;
  int          sent_total = 0;
  bit          fast_run = 1'b0;
  bit          calm_in = 1'b0;
  int          stall_left = 0;

  tftp_write_receiver_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic in_item_t pkt(logic f, logic [15:0] op, logic [15:0] blk,
                                   logic [10:0] len);
    in_item_t it;
    it.func          = f;
    it.opcode        = op;
    it.block_number  = blk;
    it.packet_length = len;
    return it;
  endfunction

  function automatic out_item_t res(logic ack, logic [15:0] ackb, logic wr,
                                    logic [9:0] plen, logic start, end_code_e fin);
    out_item_t r;
    r.send_ack       = ack;
    r.ack_block      = ackb;
    r.write_payload  = wr;
    r.payload_length = plen;
    r.transfer_start = start;
    r.transfer_end   = fin;
    return r;
  endfunction

  // Advances the receiver model by one item and returns its result.
  function automatic out_item_t step_receiver(in_item_t it);
    out_item_t   r;
    logic [15:0] prev;
    logic [10:0] diff;
    r = NoAction;
    if (rx_phase != PH_RECV) begin
      rx_phase = PH_IDLE;
      if (it.func == FuncPacket && it.opcode == OpWrq) begin
        r.send_ack       = 1'b1;
        r.ack_block      = '0;
        r.transfer_start = 1'b1;
        next_block       = 16'd1;
        quiet_cnt        = '0;
        rx_phase         = PH_RECV;
      end
    end else if (it.func == FuncPacket) begin
      prev = next_block - 16'd1;
      if (it.opcode == OpData && it.block_number == next_block) begin
        r.write_payload = 1'b1;
        diff = it.packet_length - HdrBytes;
        if (it.packet_length < HdrBytes) begin
          r.payload_length = '0;
        end else if (diff > MaxPayload) begin
          r.payload_length = MaxPayload[9:0];
        end else begin
          r.payload_length = diff[9:0];
        end
        r.send_ack  = 1'b1;
        r.ack_block = next_block;
        next_block  = next_block + 16'd1;
        quiet_cnt   = '0;
      end else if (it.opcode == OpData && it.block_number == prev) begin
        r.send_ack  = 1'b1;
        r.ack_block = prev;
      end
      if (it.packet_length != FullPacketLen) begin
        r.transfer_end = END_DONE;
        rx_phase       = PH_IDLE;
      end
    end else begin
      if (quiet_cnt < QuietMax) quiet_cnt = quiet_cnt + 8'd1;
      if (quiet_cnt >= timeout_cfg) begin
        r.transfer_end = END_TIMEOUT;
        rx_phase       = PH_IDLE;
      end
    end
    return r;
  endfunction

  task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : track
    out_item_t want;
    out_item_t pred;
    bit        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result %h with nothing expected", $time, out_data_o);
        end else begin
          want = expected_results.pop_front();
          report_field("send_ack", 16'(want.send_ack), 16'(out_data_o.send_ack));
          report_field("ack_block", want.ack_block, out_data_o.ack_block);
          report_field("write_payload", 16'(want.write_payload),
                       16'(out_data_o.write_payload));
          report_field("payload_length", 16'(want.payload_length),
                       16'(out_data_o.payload_length));
          report_field("transfer_start", 16'(want.transfer_start),
                       16'(out_data_o.transfer_start));
          report_field("transfer_end", 16'(want.transfer_end),
                       16'(out_data_o.transfer_end));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        pred  = step_receiver(in_data_i);
        expected_results.push_back(gold_en ? gold_res : pred);
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end
  end

  always @(negedge clk_i) begin : out_pacing
    int r;
    if (stall_left > 0) begin
      stall_left--;
    end else if (fast_run) begin
      out_stall_i <= ($urandom_range(15, 0) == 0);
    end else begin
      r = $urandom_range(99, 0);
      if (r < 40) begin
        out_stall_i <= 1'b0;
        stall_left  = $urandom_range(8, 0);
      end else if (r < 80) begin
        out_stall_i <= 1'b1;
        stall_left  = $urandom_range(2, 0);
      end else if (r < 94) begin
        out_stall_i <= 1'b1;
        stall_left  = $urandom_range(10, 3);
      end else if (r < 97) begin
        out_stall_i <= 1'b1;
        stall_left  = $urandom_range(60, 20);
      end else begin
        out_stall_i <= 1'b0;
        stall_left  = $urandom_range(150, 50);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(in_item_t it, bit has_gold, out_item_t gold);
    int gap;
    int r;
    if (sent_total % 100 == 0) calm_in = ($urandom_range(3, 0) == 0);
    r = $urandom_range(99, 0);
    if (fast_run || calm_in || r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(3, 1);
    else if (r < 97) gap = $urandom_range(12, 4);
    else gap = $urandom_range(60, 20);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    gold_en    <= has_gold;
    gold_res   <= gold;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent_total++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic timeout_access(bit wr, logic [7:0] val);
    @(negedge clk_i);
    psel   <= 1'b1;
    pwrite <= wr;
    paddr  <= {RegTimeout, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!wr && prdata !== {24'd0, val}) begin
      err_cnt++;
      $display("%0t: timeout register expected %0d, got %0d", $time, val, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_timeout(logic [7:0] val);
    timeout_access(1'b1, val);
    timeout_cfg = val;
    timeout_access(1'b0, val);
  endtask

  function automatic logic [10:0] rand_len();
    case ($urandom_range(5, 0))
      0:       return 11'($urandom_range(5, 0));
      1:       return 11'($urandom_range(1024, 1018));
      2:       return 11'($urandom_range(518, 514));
      default: return 11'($urandom_range(1024, 0));
    endcase
  endfunction

  function automatic in_item_t rand_item();
    return pkt(1'($urandom_range(1, 0)), 16'($urandom), 16'($urandom), rand_len());
  endfunction

  task automatic run_random(int n);
    int          sent;
    int          r;
    logic [10:0] len;
    sent = 0;
    while (sent < n) begin
      r   = $urandom_range(99, 0);
      len = ($urandom_range(9, 0) == 0) ? rand_len() : FullPacketLen;
      if (rx_phase != PH_RECV) begin
        if (r < 85) begin
          send_item(pkt(FuncPacket, OpWrq, 16'($urandom), rand_len()), 1'b0, NoAction);
        end else begin
          send_item(rand_item(), 1'b0, NoAction);
        end
        sent++;
      end else if (r < 60) begin
        send_item(pkt(FuncPacket, OpData, next_block, len), 1'b0, NoAction);
        sent++;
      end else if (r < 68) begin
        send_item(pkt(FuncPacket, OpData, next_block - 16'd1, len), 1'b0, NoAction);
        sent++;
      end else if (r < 80) begin
        send_item(pkt(FuncTick, 16'($urandom), 16'($urandom), rand_len()), 1'b0,
                  NoAction);
        sent++;
      end else if (r < 85 && (timeout_cfg <= 8'd32 || $urandom_range(3, 0) == 0)) begin
        while (rx_phase == PH_RECV) begin
          send_item(pkt(FuncTick, 16'($urandom), 16'($urandom), rand_len()), 1'b0,
                    NoAction);
          sent++;
        end
      end else if (r < 93) begin
        send_item(pkt(FuncPacket, 16'($urandom), 16'($urandom), len), 1'b0, NoAction);
        sent++;
      end else begin
        send_item(rand_item(), 1'b0, NoAction);
        sent++;
      end
    end
  endtask

  // One transfer of full blocks driven back to back, with one repeated block, ended by a short packet.
  task automatic run_fast_transfer(int blocks);
    if (rx_phase != PH_RECV) begin
      send_item(pkt(FuncPacket, OpWrq, '0, FullPacketLen), 1'b0, NoAction);
    end
    repeat (blocks) begin
      send_item(pkt(FuncPacket, OpData, next_block, FullPacketLen), 1'b0, NoAction);
    end
    send_item(pkt(FuncPacket, OpData, next_block - 16'd1, FullPacketLen), 1'b0, NoAction);
    send_item(pkt(FuncPacket, OpData, next_block, 11'd0), 1'b0, NoAction);
  endtask

  initial begin
    while (rst_ni !== 1'b1) @(posedge clk_i);
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $display("tb_tftp_write_receiver_core: done, errors");
    $finish;
  end

  initial begin : main_seq
    logic [7:0] tmo_list [5];
    dir_rows[0]  = '{pkt(FuncTick, OpNone, 16'd0, 11'd0), 1'b1, NoAction};
    dir_rows[1]  = '{pkt(FuncPacket, OpData, 16'd1, FullPacketLen), 1'b1, NoAction};
    dir_rows[2]  = '{pkt(FuncPacket, OpWrq, 16'hFFFF, 11'd0), 1'b1,
                     res(1'b1, 16'd0, 1'b0, 10'd0, 1'b1, END_NONE)};
    dir_rows[3]  = '{pkt(FuncPacket, OpData, 16'd0, FullPacketLen), 1'b1,
                     res(1'b1, 16'd0, 1'b0, 10'd0, 1'b0, END_NONE)};
    dir_rows[4]  = '{pkt(FuncPacket, OpData, 16'd1, FullPacketLen), 1'b1,
                     res(1'b1, 16'd1, 1'b1, 10'd512, 1'b0, END_NONE)};
    dir_rows[5]  = '{pkt(FuncPacket, 16'hFFFF, 16'd2, FullPacketLen), 1'b0, NoAction};
    dir_rows[6]  = '{pkt(FuncTick, 16'hFFFF, 16'hFFFF, 11'd1024), 1'b0, NoAction};
    dir_rows[7]  = '{pkt(FuncPacket, OpData, 16'd1, FullPacketLen), 1'b0, NoAction};
    dir_rows[8]  = '{pkt(FuncPacket, OpData, 16'd2, 11'd1024), 1'b1,
                     res(1'b1, 16'd2, 1'b1, 10'd1020, 1'b0, END_DONE)};
    dir_rows[9]  = '{pkt(FuncTick, OpWrq, 16'd0, FullPacketLen), 1'b1, NoAction};
    dir_rows[10] = '{pkt(FuncPacket, OpWrq, 16'd0, FullPacketLen), 1'b1,
                     res(1'b1, 16'd0, 1'b0, 10'd0, 1'b1, END_NONE)};
    dir_rows[11] = '{pkt(FuncPacket, OpData, 16'd1, 11'd3), 1'b1,
                     res(1'b1, 16'd1, 1'b1, 10'd0, 1'b0, END_DONE)};
    dir_rows[12] = '{pkt(FuncPacket, OpWrq, 16'd0, 11'd1024), 1'b0, NoAction};
    dir_rows[13] = '{pkt(FuncPacket, OpData, 16'd1, 11'd4), 1'b0, NoAction};
    dir_rows[14] = '{pkt(FuncPacket, OpWrq, 16'd7, 11'd1), 1'b0, NoAction};
    dir_rows[15] = '{pkt(FuncPacket, OpData, 16'd1, 11'd515), 1'b0, NoAction};
    dir_rows[16] = '{pkt(FuncPacket, OpWrq, 16'd0, FullPacketLen), 1'b0, NoAction};
    dir_rows[17] = '{pkt(FuncPacket, OpData, 16'd1, 11'd517), 1'b0, NoAction};
    dir_rows[18] = '{pkt(FuncPacket, OpWrq, 16'd0, FullPacketLen), 1'b0, NoAction};
    dir_rows[19] = '{pkt(FuncPacket, OpRrq, 16'd0, 11'd100), 1'b1,
                     res(1'b0, 16'd0, 1'b0, 10'd0, 1'b0, END_DONE)};
    dir_rows[20] = '{pkt(FuncPacket, OpWrq, 16'd0, FullPacketLen), 1'b0, NoAction};
    dir_rows[21] = '{pkt(FuncPacket, OpWrq, 16'd1, FullPacketLen), 1'b0, NoAction};
    dir_rows[22] = '{pkt(FuncPacket, OpData, 16'd2, FullPacketLen), 1'b0, NoAction};
    dir_rows[23] = '{pkt(FuncPacket, OpData, 16'd1, FullPacketLen), 1'b0, NoAction};
    dir_rows[24] = '{pkt(FuncPacket, OpNone, 16'd0, 11'd0), 1'b0, NoAction};
    tmo_list = '{8'd1, 8'd255, 8'd2, 8'($urandom_range(20, 3)),
                 8'($urandom_range(255, 1))};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      send_item(dir_rows[i].item, dir_rows[i].has_golden, dir_rows[i].golden);
    end
    run_random(PhaseItems);
    foreach (tmo_list[i]) begin
      settle();
      write_timeout(tmo_list[i]);
      run_random(PhaseItems);
    end
    settle();
    fast_run = 1'b1;
    run_fast_transfer(FastBlocks);
    fast_run = 1'b0;
    settle();

    if (err_cnt == 0) begin
      $display("tb_tftp_write_receiver_core: done, clean");
    end else begin
      $display("tb_tftp_write_receiver_core: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/twr_pkg.sv
hdl/twr_regs.sv
hdl/twr_fsm.sv
hdl/twr_out_buf.sv
hdl/tftp_write_receiver_core.sv
tb/tb_tftp_write_receiver_core.sv
